### src/mm64a_pkg.sv
// Package for the MurmurHash64A streaming hash block.
// Holds the sequencer state type, the hash constants and the tail mask helper.
// Used by murmur64a_string_hash_top; depends on nothing.
package mm64a_pkg;

    // Mixing constant and its 32-bit halves, fed one at a time to the multiplier
    localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT  = 47;
    localparam logic [63:0] SEED_RESET = 64'd1000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,   // wait for an input transfer
        ST_LEN,    // length * M for the start value
        ST_K1,     // first multiply of the word mix
        ST_K2,     // second multiply of the word mix
        ST_H,      // fold into running hash: h * M
        ST_FIN,    // finalizing multiply
        ST_OUT     // hand the hash to the output register
    } state_t;

    // Multiplier phase within one 64-bit constant multiply
    typedef enum logic [1:0] {
        PH_LL,     // a[31:0]  * M[31:0]
        PH_LH,     // a[31:0]  * M[63:32], low half to upper word
        PH_HL      // a[63:32] * M[31:0],  low half to upper word
    } phase_t;

    // Keep bytes below cnt of a 64-bit word
    function automatic logic [63:0] tail_mask(input logic [2:0] cnt);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < cnt) begin
                m[i*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

    // h ^ (h >> 47)
    function automatic logic [63:0] shift_xor(input logic [63:0] v);
        return v ^ (v >> MIX_SHIFT);
    endfunction

endpackage

### src/murmur64a_string_hash_top.sv
// Top level of the MurmurHash64A streaming hash block.
// Sequencer around one shared 32x32 multiplier; uses mm64a_pkg.
// Stream input of message words, stream output of the finished hash.

// MurmurHash64A over a byte message streamed as little-endian 64-bit words.
// Send one transfer per word; tuser marks the first word, which also carries
// the total byte length, and tlast marks the final word, whose byte count
// (0 to 8) selects the tail bytes. The hash appears on the m_ side one
// transfer per message. Every 64-bit multiply by the mixing constant runs as
// three passes through a single 32x32 multiplier, and s_tready is high only in
// idle: a full word takes three multiplies, a first word adds one, a tail takes
// one, and the last word adds one for finalizing plus the output register load.
// The seed is written through cfg_we/cfg_wdata; the user must do so only while
// no message is in flight, as the block itself does not enforce this.
module murmur64a_string_hash_top (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: seed
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata from bit 0: total_length[31:0], data_word[63:0], byte_count[3:0], zero pad
    input  logic [103:0] s_tdata,
    // s_tuser: first
    input  logic         s_tuser,
    input  logic         s_tlast,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: hash[63:0]
    output logic [63:0]  m_tdata
);

    mm64a_pkg::state_t state_reg, state_next;
    mm64a_pkg::phase_t phase_reg, phase_next;

    logic [63:0] seed_reg;
    logic [63:0] h_reg, h_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] word_reg, word_next;
    logic [2:0]  tcnt_reg, tcnt_next;
    logic        full_reg, full_next;
    logic        last_reg, last_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] hash_reg, hash_next;

    // Input field unpacking
    logic [31:0] in_len;
    logic [63:0] in_word;
    logic [3:0]  in_cnt;
    logic        in_full;
    logic        accept;

    assign in_len  = s_tdata[31:0];
    assign in_word = s_tdata[95:32];
    assign in_cnt  = s_tdata[99:96];
    // a short count only matters on the last word; counts above eight mean eight
    assign in_full = !s_tlast || (in_cnt >= 4'd8);

    assign s_tready = (state_reg == mm64a_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hash_reg;

    // Shared multiplier: one 32x32 partial product per cycle
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mul_res;
    logic        in_mul;
    logic        mul_done;

    always_comb begin
        case (phase_reg)
            mm64a_pkg::PH_LL: begin
                mul_a = a_reg[31:0];
                mul_b = mm64a_pkg::MIX_MUL_LO;
            end
            mm64a_pkg::PH_LH: begin
                mul_a = a_reg[31:0];
                mul_b = mm64a_pkg::MIX_MUL_HI;
            end
            mm64a_pkg::PH_HL: begin
                mul_a = a_reg[63:32];
                mul_b = mm64a_pkg::MIX_MUL_LO;
            end
            default: begin
                mul_a = a_reg[31:0];
                mul_b = mm64a_pkg::MIX_MUL_LO;
            end
        endcase
    end

    assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
    assign mul_res = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
    assign in_mul  = (state_reg == mm64a_pkg::ST_LEN) || (state_reg == mm64a_pkg::ST_K1) ||
                     (state_reg == mm64a_pkg::ST_K2)  || (state_reg == mm64a_pkg::ST_H)  ||
                     (state_reg == mm64a_pkg::ST_FIN);
    assign mul_done = in_mul && (phase_reg == mm64a_pkg::PH_HL);

    // Dispatch after the start value is known: pick the first step of the word
    logic [63:0]         disp_h;
    logic [63:0]         disp_word;
    logic [2:0]          disp_cnt;
    logic                disp_full;
    logic [63:0]         disp_a;
    mm64a_pkg::state_t   disp_state;

    always_comb begin
        if (state_reg == mm64a_pkg::ST_IDLE) begin
            disp_h    = h_reg;
            disp_word = in_word;
            disp_cnt  = in_cnt[2:0];
            disp_full = in_full;
        end else begin
            disp_h    = seed_reg ^ mul_res;
            disp_word = word_reg;
            disp_cnt  = tcnt_reg;
            disp_full = full_reg;
        end
        if (disp_full) begin
            disp_a     = disp_word;
            disp_state = mm64a_pkg::ST_K1;
        end else if (disp_cnt != 3'd0) begin
            disp_a     = disp_h ^ (disp_word & mm64a_pkg::tail_mask(disp_cnt));
            disp_state = mm64a_pkg::ST_H;
        end else begin
            disp_a     = mm64a_pkg::shift_xor(disp_h);
            disp_state = mm64a_pkg::ST_FIN;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mm64a_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = s_tuser ? mm64a_pkg::ST_LEN : disp_state;
                end
            end
            mm64a_pkg::ST_LEN: begin
                if (mul_done) state_next = disp_state;
            end
            mm64a_pkg::ST_K1: begin
                if (mul_done) state_next = mm64a_pkg::ST_K2;
            end
            mm64a_pkg::ST_K2: begin
                if (mul_done) state_next = mm64a_pkg::ST_H;
            end
            mm64a_pkg::ST_H: begin
                if (mul_done) state_next = last_reg ? mm64a_pkg::ST_FIN : mm64a_pkg::ST_IDLE;
            end
            mm64a_pkg::ST_FIN: begin
                if (mul_done) state_next = mm64a_pkg::ST_OUT;
            end
            mm64a_pkg::ST_OUT: begin
                if (!m_valid_reg || m_tready) state_next = mm64a_pkg::ST_IDLE;
            end
            default: state_next = mm64a_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb begin
        phase_next   = phase_reg;
        h_next       = h_reg;
        a_next       = a_reg;
        acc_next     = acc_reg;
        word_next    = word_reg;
        tcnt_next    = tcnt_reg;
        full_next    = full_reg;
        last_next    = last_reg;
        hash_next    = hash_reg;
        m_valid_next = m_valid_reg && !m_tready;

        // advance the multiplier phase and accumulate the partial product
        if (in_mul) begin
            case (phase_reg)
                mm64a_pkg::PH_LL: begin
                    acc_next   = mul_p;
                    phase_next = mm64a_pkg::PH_LH;
                end
                mm64a_pkg::PH_LH: begin
                    acc_next   = mul_res;
                    phase_next = mm64a_pkg::PH_HL;
                end
                default: begin
                    acc_next   = mul_res;
                    phase_next = mm64a_pkg::PH_LL;
                end
            endcase
        end

        case (state_reg)
            mm64a_pkg::ST_IDLE: begin
                // latch the word and choose the first operation
                if (accept) begin
                    word_next  = in_word;
                    tcnt_next  = in_cnt[2:0];
                    full_next  = in_full;
                    last_next  = s_tlast;
                    phase_next = mm64a_pkg::PH_LL;
                    a_next     = s_tuser ? {32'd0, in_len} : disp_a;
                end
            end
            mm64a_pkg::ST_LEN: begin
                if (mul_done) begin
                    h_next = disp_h;
                    a_next = disp_a;
                end
            end
            mm64a_pkg::ST_K1: begin
                if (mul_done) a_next = mm64a_pkg::shift_xor(mul_res);
            end
            mm64a_pkg::ST_K2: begin
                if (mul_done) a_next = h_reg ^ mul_res;
            end
            mm64a_pkg::ST_H: begin
                if (mul_done) begin
                    h_next = mul_res;
                    a_next = mm64a_pkg::shift_xor(mul_res);
                end
            end
            mm64a_pkg::ST_FIN: begin
                if (mul_done) h_next = mm64a_pkg::shift_xor(mul_res);
            end
            mm64a_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    hash_next    = h_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mm64a_pkg::ST_IDLE;
            phase_reg   <= mm64a_pkg::PH_LL;
            m_valid_reg <= 1'b0;
            seed_reg    <= mm64a_pkg::SEED_RESET;
            h_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            h_reg       <= h_next;
            if (cfg_we) seed_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        acc_reg  <= acc_next;
        word_reg <= word_next;
        tcnt_reg <= tcnt_next;
        full_reg <= full_next;
        last_reg <= last_next;
        hash_reg <= hash_next;
    end

endmodule

### tb/murmur64a_hash_checker.sv
// Checker for murmur64a_string_hash_top: watches the seed writes and both stream channels.
// Predicts each message hash on its own and compares every result transfer with it.
// Depends on mm64a_pkg for the mixing constants and the seed reset value.
module murmur64a_hash_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // s_tdata from bit 0: total_length[31:0], data_word[63:0], byte_count[3:0], zero pad
    input  logic [103:0] s_tdata,
    // s_tuser: first
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata from bit 0: hash[63:0]
    input  logic [63:0]  m_tdata,
    output int unsigned  fail_count,
    output int unsigned  hashes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] seed_q;
    logic [63:0] running_hash_q;
    logic [63:0] expected_hashes[$];

    // Multiply, shift-xor, multiply on one full message word
    function automatic logic [63:0] scramble_word(input logic [63:0] k);
        logic [63:0] v;
        v = k * mm64a_pkg::MIX_MUL;
        v = v ^ (v >> mm64a_pkg::MIX_SHIFT);
        return v * mm64a_pkg::MIX_MUL;
    endfunction

    // Closing shift-xor, multiply, shift-xor
    function automatic logic [63:0] avalanche(input logic [63:0] h);
        logic [63:0] v;
        v = h ^ (h >> mm64a_pkg::MIX_SHIFT);
        v = v * mm64a_pkg::MIX_MUL;
        return v ^ (v >> mm64a_pkg::MIX_SHIFT);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < 50) begin
            $display("[%0t] MISMATCH %s: got %h, want %h", $time, what, got, want);
        end
        fail_count++;
    endtask

    // Fold one input transfer into the running hash; queue the hash on the last word
    task automatic absorb_transfer(input logic first, input logic [31:0] len,
                                   input logic [63:0] word, input logic [3:0] count,
                                   input logic last);
        logic [63:0] h;
        logic [3:0]  n;
        h = running_hash_q;
        n = (count > 4'd8) ? 4'd8 : count;
        if (first) begin
            h = seed_q ^ ({32'd0, len} * mm64a_pkg::MIX_MUL);
        end
        if (!last || n == 4'd8) begin
            h = (h ^ scramble_word(word)) * mm64a_pkg::MIX_MUL;
        end else if (n != 4'd0) begin
            h = (h ^ (word & ((64'd1 << (n * 8)) - 64'd1))) * mm64a_pkg::MIX_MUL;
        end
        if (last) begin
            h = avalanche(h);
            expected_hashes.push_back(h);
        end
        running_hash_q = h;
    endtask

    // Check the result transfer first: it never belongs to a word taken at the same edge
    always @(posedge aclk) begin : watch
        logic [63:0] want;
        if (!aresetn) begin
            seed_q         = mm64a_pkg::SEED_RESET;
            running_hash_q = '0;
            expected_hashes.delete();
        end else begin
            if (cfg_we) begin
                seed_q = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                if (expected_hashes.size() == 0) begin
                    report_mismatch("hash with none pending", m_tdata, '0);
                end else begin
                    want = expected_hashes.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch("hash", m_tdata, want);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_transfer(s_tuser, s_tdata[31:0], s_tdata[95:32], s_tdata[99:96],
                                s_tlast);
            end
        end
        hashes_due = expected_hashes.size();
    end

endmodule

### tb/tb_murmur64a_string_hash_top.sv
// Testbench top for murmur64a_string_hash_top: clock, reset, seed writes and message stimulus.
// Checking lives in murmur64a_hash_checker; this module only drives and gives the verdict.
// Depends on mm64a_pkg, murmur64a_string_hash_top and murmur64a_hash_checker.
module tb_murmur64a_string_hash_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF        = 5;
    localparam int unsigned RESET_CYCLES    = 7;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned PHASE_WORDS     = 175;
    localparam int unsigned NUM_PHASES      = 6;
    localparam longint unsigned CYCLE_LIMIT = 400_000;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [63:0]   cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [103:0]  s_tdata   = '0;
    logic          s_tuser   = 1'b0;
    logic          s_tlast   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [63:0]   m_tdata;

    int unsigned     fail_count;
    int unsigned     hashes_due;
    int unsigned     words_sent    = 0;
    longint unsigned cycle_count   = 0;
    bit              steady        = 1'b0;
    bit              hold_off_req  = 1'b0;
    bit              hold_off_done = 1'b0;

    murmur64a_string_hash_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    murmur64a_hash_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .hashes_due (hashes_due)
    );

    always #CLK_HALF aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("murmur64a_string_hash_top verification failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            m_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge aclk);
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 18);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one word after a random gap and hold it until the transfer; enter and leave
    // at a falling edge with nothing yet driven in that step
    task automatic send_word(input logic first, input logic [31:0] len,
                             input logic [63:0] word, input logic [3:0] count,
                             input logic last);
        while (!steady && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tlast  <= last;
        s_tdata  <= {4'd0, count, word, len};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        @(negedge aclk);
    endtask

    // Stop offering, wait for every pending hash, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (hashes_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed messages with random content, the rest stray words
    task automatic send_messages(input int unsigned quota);
        int unsigned start;
        int unsigned n_full;
        int unsigned tail;
        int unsigned i;
        logic [31:0] len;
        logic [3:0]  cnt;
        bit          full_last;
        start = words_sent;
        while (words_sent - start < quota) begin
            if ($urandom_range(99) < 85) begin
                n_full    = ($urandom_range(9) == 0) ? $urandom_range(16) : $urandom_range(4);
                tail      = $urandom_range(7);
                full_last = (tail == 0) && (n_full != 0) && ($urandom_range(1) == 1);
                len       = 32'(n_full * 8 + tail);
                if ($urandom_range(9) == 0) begin
                    len = $urandom;
                end
                for (i = 0; i < n_full; i++) begin
                    cnt = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'd8;
                    send_word(i == 0, len, rand64(), cnt, full_last && (i == n_full - 1));
                end
                if (!full_last) begin
                    cnt = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'(tail);
                    send_word(n_full == 0, len, rand64(), cnt, 1'b1);
                end
            end else begin
                send_word(1'($urandom_range(1)), $urandom, rand64(),
                          4'($urandom_range(15)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin : stimulus
        logic [63:0] seeds [NUM_PHASES];
        int unsigned p;
        seeds = '{64'd0, {64{1'b1}}, rand64(), 64'd1, rand64() | 64'h8000_0000_0000_0000,
                  mm64a_pkg::SEED_RESET};

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset seed
        // tail on the zero running hash, no start seen yet
        send_word(1'b0, 32'd0, 64'h0123_4567_89ab_cdef, 4'd3, 1'b1);
        // empty message, then a single full last word
        send_word(1'b1, 32'd0, 64'd0, 4'd0, 1'b1);
        send_word(1'b1, 32'd8, {64{1'b1}}, 4'd8, 1'b1);
        // largest length with a seven-byte tail
        send_word(1'b1, 32'hffff_ffff, {64{1'b1}}, 4'd7, 1'b1);
        // short counts on inner words, count above eight on the last word
        send_word(1'b1, 32'd21, rand64(), 4'd5, 1'b0);
        send_word(1'b0, 32'd21, {64{1'b1}}, 4'd0, 1'b0);
        send_word(1'b0, 32'd21, 64'd0, 4'd8, 1'b0);
        send_word(1'b0, 32'd21, {64{1'b1}}, 4'd15, 1'b1);
        // carry on from the last finished hash; one-byte tail with junk above it
        send_word(1'b0, 32'd0, rand64(), 4'd8, 1'b0);
        send_word(1'b0, 32'd0, {64{1'b1}}, 4'd1, 1'b1);
        // restart mid-message, then count twelve on the last word
        send_word(1'b1, 32'd16, 64'h8000_0000_0000_0000, 4'd8, 1'b0);
        send_word(1'b1, 32'd9, rand64(), 4'd12, 1'b1);
        // empty tail ignores its data; zero tail bytes
        send_word(1'b1, 32'd0, {64{1'b1}}, 4'd0, 1'b1);
        send_word(1'b1, 32'd7, 64'd0, 4'd7, 1'b1);
        drain();

        // Random phases, one seed each; the hold-off falls in the second, no idling in the fourth
        for (p = 0; p < NUM_PHASES; p++) begin
            write_seed(seeds[p]);
            steady = (p == 3);
            if (p == 1) begin
                hold_off_req = 1'b1;
            end
            send_messages(PHASE_WORDS);
            drain();
        end

        if (fail_count == 0) begin
            $display("murmur64a_string_hash_top verification clean");
        end else begin
            $display("murmur64a_string_hash_top verification failed");
        end
        $finish;
    end

endmodule

### sim.f
src/mm64a_pkg.sv
src/murmur64a_string_hash_top.sv
tb/murmur64a_hash_checker.sv
tb/tb_murmur64a_string_hash_top.sv
